// File: rtl/pcrd_pkg.sv
package pcrd_pkg;

   localparam logic [31:0] DEV_MAGIC = 32'h5048_5630;
   localparam logic [31:0] DEV_ABI   = 32'h0001_0000;
   localparam logic [31:0] DEV_CAPS  = 32'h0000_001f;
   localparam logic [31:0] DEV_TEN   = 32'd10;

   localparam logic signed [31:0] Q_ONE   = 32'sd1073741824;
   localparam logic signed [32:0] DECAY_Q = 33'sd1063004406;

   localparam logic [18:0] CYC_PER_STEP = 19'd64;
   localparam logic [3:0]  BARRIER_SET  = 4'd8;
   localparam int          MIN_RINGDOWN = 8;

   localparam logic [11:0] ADDR_MAGIC   = 12'h000;
   localparam logic [11:0] ADDR_ABI     = 12'h004;
   localparam logic [11:0] ADDR_BACKEND = 12'h008;
   localparam logic [11:0] ADDR_CAPS    = 12'h00c;
   localparam logic [11:0] ADDR_STATUS  = 12'h010;
   localparam logic [11:0] ADDR_ERROR   = 12'h014;
   localparam logic [11:0] ADDR_GEN     = 12'h018;
   localparam logic [11:0] ADDR_REINIT  = 12'h01c;
   localparam logic [11:0] ADDR_ARG0    = 12'h020;
   localparam logic [11:0] ADDR_ARG1    = 12'h024;
   localparam logic [11:0] ADDR_CMD     = 12'h028;
   localparam logic [11:0] ADDR_BARRIER = 12'h02c;
   localparam logic [11:0] ADDR_CYCLES  = 12'h030;
   localparam logic [11:0] ADDR_BND_I   = 12'h040;
   localparam logic [11:0] ADDR_BND_Q   = 12'h048;
   localparam logic [11:0] ADDR_BND_EN  = 12'h050;
   localparam logic [11:0] ADDR_CONST10 = 12'h058;
   localparam logic [11:0] ADDR_CONST0  = 12'h05c;
   localparam logic [11:0] ADDR_OWNER   = 12'h060;
   localparam logic [11:0] ADDR_PROGRAM = 12'h064;

   localparam logic [31:0] OP_LEASE   = 32'd1;
   localparam logic [31:0] OP_PREPARE = 32'd2;
   localparam logic [31:0] OP_ISOLATE = 32'd3;
   localparam logic [31:0] OP_EVOLVE  = 32'd4;
   localparam logic [31:0] OP_PROJECT = 32'd5;
   localparam logic [31:0] OP_INVERT  = 32'd6;
   localparam logic [31:0] OP_RESTORE = 32'd7;
   localparam logic [31:0] OP_REUSE   = 32'd8;
   localparam logic [31:0] OP_RELEASE = 32'd9;
   localparam logic [31:0] OP_REINIT  = 32'd10;

   localparam logic [3:0] ERR_OK       = 4'd0;
   localparam logic [3:0] ERR_STATE    = 4'd1;
   localparam logic [3:0] ERR_ARGUMENT = 4'd2;
   localparam logic [3:0] ERR_PROJECT  = 4'd3;
   localparam logic [3:0] ERR_INVERT   = 4'd4;
   localparam logic [3:0] ERR_RESTORE  = 4'd5;
   localparam logic [3:0] ERR_REUSE    = 4'd7;
   localparam logic [3:0] ERR_CUSTODY  = 4'd8;

endpackage

// File: rtl/pcrd_req_if.sv
interface pcrd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [11:0] access_address;
   logic [31:0] write_data;

   modport source (output valid, req_type, access_address, write_data, input ready);
   modport sink   (input valid, req_type, access_address, write_data, output ready);
endinterface

// File: rtl/pcrd_rsp_if.sv
interface pcrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

// File: rtl/pcrd_csr_if.sv
interface pcrd_csr_if;
   logic valid;
   logic ready;
   logic carrier_on;

   modport source (output valid, carrier_on, input ready);
   modport sink   (input valid, carrier_on, output ready);
endinterface

// File: rtl/phase_custody_register_device_top.sv
// Register-mapped custody device. Each request word is one bus access; every
// accepted word returns exactly one response word (read data, or zero for a
// write). Reads and plain register writes do not use the sequencer. Commands that
// iterate run under a small sequencer and hold off new requests while they run;
// evolve and project share one 33x33 multiplier. Prepare runs PREPARE_STEPS
// steps, each tracking the I lane, then the Q lane. An evolve step rotates the
// carrier, squares it for its energy, forms two decay products and squares
// again, all in the multiplier, then updates tracking; project squares the
// boundary lanes for its energy. The response word of a write is posted when
// the request is taken, so the response side never waits on the sequencer.
// The carrier enable register is written through the csr channel, which is always ready.
module phase_custody_register_device_top #(
   parameter int MAX_EVOLVE_STEPS = 4096,
   parameter int PREPARE_STEPS    = 256
) (
   input logic clock,
   input logic reset,
   pcrd_req_if.sink   req,
   pcrd_rsp_if.source rsp,
   pcrd_csr_if.sink   csr
);
   import pcrd_pkg::*;

   localparam int RD_W     = $clog2(MAX_EVOLVE_STEPS + 1);
   localparam int STEP_MAX = (MAX_EVOLVE_STEPS > PREPARE_STEPS) ? MAX_EVOLVE_STEPS
                                                               : PREPARE_STEPS;
   localparam int CNT_W    = $clog2(STEP_MAX + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_EVOL, ST_PROJ} state_type;

   state_type state_ff;
   logic [2:0]       phase_ff;
   logic [CNT_W-1:0] step_ff;
   logic [RD_W-1:0]  steps_ff;

   logic        carrier_on_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   logic leased_ff, prepared_ff, isolated_ff, pending_ff, response_ff, spent_ff;
   logic [3:0]  error_ff, barrier_ff;
   logic [31:0] granted_owner_ff, granted_program_ff, asked_owner_ff, asked_program_ff;
   logic [31:0] generation_ff, reinit_ff, arg0_ff, arg1_ff;
   logic        arm_ff;
   logic [RD_W-1:0] ringdown_ff;
   logic [18:0] cycle_ff;
   logic [39:0] dissipated_ff;
   logic signed [31:0] src_i_ff, src_q_ff, car_i_ff, car_q_ff;
   logic signed [31:0] det_i_ff, det_q_ff, bnd_i_ff, bnd_q_ff;
   logic [32:0] bnd_energy_ff;

   // Shared multiplier and its scratch registers.
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic [63:0]        sq_ff;
   logic [33:0]        before_ff;
   logic signed [32:0] ri_ff, rq_ff;

   logic accept, dyn_zero, custody_bad, evolve_ok;
   logic [63:0] status_word, read_word;
   logic [63:0] energy_sum;
   logic [33:0] energy_now;
   logic signed [65:0] prod_shift;
   logic signed [31:0] lane_src, lane_car, lane_det, car_next, car_used, det_next;
   logic signed [32:0] diff_car, diff_det, ri_c, rq_c;
   logic signed [31:0] tgt_i, tgt_q;
   logic signed [32:0] ev_di, ev_dq;
   logic [RD_W:0]      ringdown_sum;

   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept     = req.valid && req.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign csr.ready  = 1'b1;

   always_comb begin
      dyn_zero = (src_i_ff == 0) && (src_q_ff == 0) && (car_i_ff == 0) && (car_q_ff == 0)
         && (det_i_ff == 0) && (det_q_ff == 0) && (bnd_i_ff == 0) && (bnd_q_ff == 0)
         && (bnd_energy_ff == '0) && (cycle_ff == '0) && (dissipated_ff == '0)
         && (barrier_ff == '0) && (ringdown_ff == '0);
      status_word = 64'({carrier_on_ff, (reinit_ff != '0), spent_ff, response_ff,
                         pending_ff, isolated_ff, prepared_ff, leased_ff,
                         (!leased_ff && !spent_ff && dyn_zero)});
      case (req.access_address)
         ADDR_MAGIC:   read_word = 64'(DEV_MAGIC);
         ADDR_ABI:     read_word = 64'(DEV_ABI);
         ADDR_BACKEND: read_word = '0;
         ADDR_CAPS:    read_word = 64'(DEV_CAPS);
         ADDR_STATUS:  read_word = status_word;
         ADDR_ERROR:   read_word = 64'(error_ff);
         ADDR_GEN:     read_word = 64'(generation_ff);
         ADDR_REINIT:  read_word = 64'(reinit_ff);
         ADDR_ARG0:    read_word = 64'(arg0_ff);
         ADDR_ARG1:    read_word = 64'(arg1_ff);
         ADDR_BARRIER: read_word = 64'(barrier_ff);
         ADDR_CYCLES:  read_word = 64'(cycle_ff);
         ADDR_BND_I:   read_word = response_ff ? 64'(bnd_i_ff) : '1;
         ADDR_BND_Q:   read_word = response_ff ? 64'(bnd_q_ff) : '1;
         ADDR_BND_EN:  read_word = response_ff ? 64'(bnd_energy_ff) : '1;
         ADDR_CONST10: read_word = 64'(DEV_TEN);
         ADDR_CONST0:  read_word = '0;
         ADDR_OWNER:   read_word = 64'(asked_owner_ff);
         ADDR_PROGRAM: read_word = 64'(asked_program_ff);
         default:      read_word = '1;
      endcase
   end

   // Command qualification.
   always_comb begin
      custody_bad = leased_ff && (req.write_data != OP_LEASE) &&
         ((asked_owner_ff != granted_owner_ff) || (asked_program_ff != granted_program_ff));
      ringdown_sum = (RD_W+1)'(ringdown_ff) + (RD_W+1)'(arg0_ff[RD_W-1:0]);
      evolve_ok = (arg0_ff != '0) && (arg0_ff <= 32'(MAX_EVOLVE_STEPS)) &&
         (ringdown_sum <= (RD_W+1)'(MAX_EVOLVE_STEPS));
   end

   // Multiplier operand selection by sequencer phase.
   always_comb begin
      mul_a = 33'(car_i_ff);
      mul_b = 33'(car_i_ff);
      case (state_ff)
         ST_EVOL: begin
            case (phase_ff)
               3'd1, 3'd5: begin mul_a = 33'(car_q_ff); mul_b = 33'(car_q_ff); end
               3'd2:       begin mul_a = ri_ff;         mul_b = DECAY_Q; end
               3'd3:       begin mul_a = rq_ff;         mul_b = DECAY_Q; end
               default:    begin mul_a = 33'(car_i_ff); mul_b = 33'(car_i_ff); end
            endcase
         end
         ST_PROJ: begin
            if (phase_ff == 3'd0) begin
               mul_a = 33'(det_i_ff); mul_b = 33'(det_i_ff);
            end else begin
               mul_a = 33'(det_q_ff); mul_b = 33'(det_q_ff);
            end
         end
         default: begin
            mul_a = 33'(car_i_ff);
            mul_b = 33'(car_i_ff);
         end
      endcase
   end

   // Datapath helpers.
   always_comb begin
      energy_sum = sq_ff + prod_ff[63:0];
      energy_now = energy_sum[63:30];
      prod_shift = prod_ff >>> 30;
      ri_c = 33'(car_i_ff) - 33'(car_q_ff >>> 12);
      rq_c = 33'(car_q_ff) + 33'(car_i_ff >>> 12);
      lane_src = phase_ff[0] ? src_q_ff : src_i_ff;
      lane_car = phase_ff[0] ? car_q_ff : car_i_ff;
      lane_det = phase_ff[0] ? det_q_ff : det_i_ff;
      diff_car = 33'(lane_src) - 33'(lane_car);
      car_next = lane_car + 32'(diff_car >>> 3);
      car_used = carrier_on_ff ? car_next : lane_car;
      diff_det = 33'(car_used) - 33'(lane_det);
      det_next = lane_det + 32'(diff_det >>> 2);
      tgt_i = car_i_ff + (src_i_ff >>> 20);
      tgt_q = car_q_ff + (src_q_ff >>> 20);
      ev_di = 33'(tgt_i) - 33'(det_i_ff);
      ev_dq = 33'(tgt_q) - 33'(det_q_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         step_ff <= '0;
         steps_ff <= '0;
         carrier_on_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         leased_ff <= 1'b0; prepared_ff <= 1'b0; isolated_ff <= 1'b0;
         pending_ff <= 1'b0; response_ff <= 1'b0; spent_ff <= 1'b0;
         error_ff <= ERR_OK; barrier_ff <= '0;
         granted_owner_ff <= '0; granted_program_ff <= '0;
         asked_owner_ff <= '0; asked_program_ff <= '0;
         generation_ff <= '0; reinit_ff <= '0; arg0_ff <= '0; arg1_ff <= '0;
         arm_ff <= 1'b0; ringdown_ff <= '0; cycle_ff <= '0; dissipated_ff <= '0;
         src_i_ff <= '0; src_q_ff <= '0; car_i_ff <= '0; car_q_ff <= '0;
         det_i_ff <= '0; det_q_ff <= '0; bnd_i_ff <= '0; bnd_q_ff <= '0;
         bnd_energy_ff <= '0;
      end else begin
         if (csr.valid) begin
            carrier_on_ff <= csr.carrier_on;
         end
         // A new word replaces the one being taken in the same cycle.
         rsp_valid_ff <= accept || (rsp_valid_ff && !rsp.ready);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_data_ff  <= req.req_type ? '0 : read_word;
                  if (req.req_type) begin
                     case (req.access_address)
                        ADDR_ARG0:    arg0_ff <= req.write_data;
                        ADDR_ARG1:    arg1_ff <= req.write_data;
                        ADDR_OWNER:   asked_owner_ff <= req.write_data;
                        ADDR_PROGRAM: asked_program_ff <= req.write_data;
                        ADDR_CMD: begin
                           if (custody_bad) begin
                              error_ff <= ERR_CUSTODY;
                           end else begin
                              case (req.write_data)
                                 OP_LEASE: begin
                                    if (leased_ff || spent_ff || !dyn_zero ||
                                        asked_owner_ff == '0 || asked_program_ff == '0) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       granted_owner_ff <= asked_owner_ff;
                                       granted_program_ff <= asked_program_ff;
                                       leased_ff <= 1'b1;
                                    end
                                 end
                                 OP_PREPARE: begin
                                    if (!leased_ff || prepared_ff || isolated_ff ||
                                        arg0_ff > 32'd1) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       arm_ff <= arg0_ff[0];
                                       src_i_ff <= arg0_ff[0] ? -Q_ONE : Q_ONE;
                                       src_q_ff <= '0;
                                       prepared_ff <= 1'b1;
                                       phase_ff <= '0;
                                       step_ff <= '0;
                                       state_ff <= ST_PREP;
                                    end
                                 end
                                 OP_ISOLATE: begin
                                    if (!leased_ff || !prepared_ff || isolated_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       barrier_ff <= BARRIER_SET;
                                       isolated_ff <= 1'b1;
                                       if (carrier_on_ff) begin
                                          car_q_ff <= car_q_ff + (src_i_ff >>> 12);
                                       end
                                    end
                                 end
                                 OP_EVOLVE: begin
                                    if (!leased_ff || !prepared_ff || !isolated_ff ||
                                        pending_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else if (!evolve_ok) begin
                                       error_ff <= ERR_ARGUMENT;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       steps_ff <= arg0_ff[RD_W-1:0];
                                       phase_ff <= '0;
                                       step_ff <= '0;
                                       state_ff <= ST_EVOL;
                                    end
                                 end
                                 OP_PROJECT: begin
                                    if (!leased_ff || !prepared_ff || pending_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else if (!isolated_ff || barrier_ff != BARRIER_SET ||
                                                 ringdown_ff < RD_W'(MIN_RINGDOWN)) begin
                                       error_ff <= ERR_PROJECT;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       bnd_i_ff <= det_i_ff;
                                       bnd_q_ff <= det_q_ff;
                                       pending_ff <= 1'b1;
                                       phase_ff <= '0;
                                       state_ff <= ST_PROJ;
                                    end
                                 end
                                 OP_INVERT, OP_RESTORE: begin
                                    if (!leased_ff || !pending_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= (req.write_data == OP_INVERT) ?
                                                   ERR_INVERT : ERR_RESTORE;
                                    end
                                 end
                                 OP_REUSE: error_ff <= ERR_REUSE;
                                 OP_RELEASE: begin
                                    if (!leased_ff || !pending_ff || response_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       response_ff <= 1'b1;
                                       pending_ff <= 1'b0;
                                       leased_ff <= 1'b0;
                                       spent_ff <= 1'b1;
                                       granted_owner_ff <= '0;
                                       granted_program_ff <= '0;
                                    end
                                 end
                                 OP_REINIT: begin
                                    if (!spent_ff) begin
                                       error_ff <= ERR_STATE;
                                    end else begin
                                       error_ff <= ERR_OK;
                                       reinit_ff <= reinit_ff + 32'd1;
                                       generation_ff <= generation_ff + 32'd1;
                                       leased_ff <= 1'b0; prepared_ff <= 1'b0;
                                       isolated_ff <= 1'b0; pending_ff <= 1'b0;
                                       response_ff <= 1'b0; spent_ff <= 1'b0;
                                       granted_owner_ff <= '0; granted_program_ff <= '0;
                                       asked_owner_ff <= '0; asked_program_ff <= '0;
                                       arg0_ff <= '0; arg1_ff <= '0; arm_ff <= 1'b0;
                                       barrier_ff <= '0; ringdown_ff <= '0;
                                       cycle_ff <= '0; dissipated_ff <= '0;
                                       bnd_energy_ff <= '0;
                                       src_i_ff <= '0; src_q_ff <= '0;
                                       car_i_ff <= '0; car_q_ff <= '0;
                                       det_i_ff <= '0; det_q_ff <= '0;
                                       bnd_i_ff <= '0; bnd_q_ff <= '0;
                                    end
                                 end
                                 default: error_ff <= ERR_ARGUMENT;
                              endcase
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            ST_PREP: begin
               // One tracking lane per cycle: I on even phases, Q on odd.
               if (phase_ff[0]) begin
                  car_q_ff <= car_used;
                  det_q_ff <= det_next;
                  cycle_ff <= cycle_ff + CYC_PER_STEP;
                  step_ff <= step_ff + 1'b1;
                  phase_ff <= '0;
                  if (step_ff == CNT_W'(PREPARE_STEPS - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  car_i_ff <= car_used;
                  det_i_ff <= det_next;
                  phase_ff <= 3'd1;
               end
            end
            ST_EVOL: begin
               phase_ff <= (phase_ff >= 3'd6) ? 3'd0 : phase_ff + 3'd1;
               case (phase_ff)
                  3'd0: begin
                     ri_ff <= ri_c;
                     rq_ff <= rq_c;
                  end
                  3'd1, 3'd5: sq_ff <= prod_ff[63:0];
                  3'd2: before_ff <= energy_now;
                  3'd3: car_i_ff <= prod_shift[31:0];
                  3'd4: car_q_ff <= prod_shift[31:0];
                  3'd6: begin
                     if (before_ff > energy_now) begin
                        dissipated_ff <= dissipated_ff + 40'(before_ff - energy_now);
                     end
                     det_i_ff <= det_i_ff + 32'(ev_di >>> 2);
                     det_q_ff <= det_q_ff + 32'(ev_dq >>> 2);
                     cycle_ff <= cycle_ff + CYC_PER_STEP;
                     ringdown_ff <= ringdown_ff + 1'b1;
                     step_ff <= step_ff + 1'b1;
                     if ((step_ff + 1'b1) == CNT_W'(steps_ff)) begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            ST_PROJ: begin
               phase_ff <= (phase_ff == 3'd2) ? 3'd0 : phase_ff + 3'd1;
               if (phase_ff == 3'd1) begin
                  sq_ff <= prod_ff[63:0];
               end else if (phase_ff == 3'd2) begin
                  bnd_energy_ff <= energy_now[32:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The sequencer holds off requests while a command iterates.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request taken while sequencer busy");

   // Every accepted word leaves a response word behind.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   // The ringdown count never passes its bound.
   assert property (@(posedge clock) disable iff (reset)
      ringdown_ff <= RD_W'(MAX_EVOLVE_STEPS))
      else $error("ringdown count out of range");

   // A released boundary always belongs to a spent, unleased transaction.
   assert property (@(posedge clock) disable iff (reset)
      response_ff |-> (spent_ff && !leased_ff))
      else $error("response ready without spent custody");

endmodule
